// ===== sv/matrix_multiply_core_macros.svh =====
// Assertion macros used by the checker of the matrix multiply core.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef MATRIX_MULTIPLY_CORE_MACROS_SVH
`define MATRIX_MULTIPLY_CORE_MACROS_SVH

// Same-cycle implication, ignored while reset is applied.
`define MM_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("matrix multiply core: assertion failed");

// Next-cycle implication, ignored while reset is applied.
`define MM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("matrix multiply core: assertion failed");

// Condition that must hold in the cycle after reset is sampled low.
`define MM_ASSERT_AFTER_RESET(lbl, cons) \
  lbl: assert property (@(posedge clk) !rst_n |=> (cons)) \
    else $error("matrix multiply core: reset assertion failed");

`endif

// ===== sv/mm_pkg.sv =====
`timescale 1ns / 1ps

package mm_pkg;

  localparam int MAX_DIM_DEF   = 8;
  localparam int FRAC_BITS_DEF = 16;

  localparam int DIM_W  = 4;
  localparam int ELEM_W = 32;

  // Request codes of the input item.
  localparam logic [1:0] REQ_LOAD_A  = 2'd0;
  localparam logic [1:0] REQ_LOAD_B  = 2'd1;
  localparam logic [1:0] REQ_COMPUTE = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] CFG_NUM_ROWS  = 2'd0;
  localparam logic [1:0] CFG_INNER_DIM = 2'd1;
  localparam logic [1:0] CFG_NUM_COLS  = 2'd2;

  localparam logic [DIM_W-1:0] DIM_RESET = 4'd4;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN
  } mm_state_t;

endpackage

// ===== sv/matrix_multiply_core.sv =====
`timescale 1ns / 1ps
// Loads are accepted while in_ready is high; in_ready is high whenever no product run is in progress.
// A compute item gives rows*cols results; for each result one store read per cycle is made from
// each memory along the inner dimension, and the data pass through read, multiply and accumulate stages.
// A stalled output holds back the next result, whose reads start only once the current one is loaded out.
// Synchronous active-low reset clears the control state and sets all sizes to 4;
// the A and B memories are not cleared and hold nothing defined until written.
module matrix_multiply_core #(
  parameter int MAX_DIM   = mm_pkg::MAX_DIM_DEF,
  parameter int FRAC_BITS = mm_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [1:0]                        in_req_type,
  input  logic [2:0]                        in_elem_row,
  input  logic [2:0]                        in_elem_col,
  input  logic signed [mm_pkg::ELEM_W-1:0]  in_elem_value,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [2:0]                        out_row,
  output logic [2:0]                        out_col,
  output logic signed [mm_pkg::ELEM_W-1:0]  out_product_value,
  output logic                              out_saturated,
  output logic                              out_last,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [1:0]                        cfg_index,
  input  logic [mm_pkg::DIM_W-1:0]          cfg_data
);

  localparam int IDX_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int DEPTH  = MAX_DIM * MAX_DIM;
  localparam int AW     = $clog2(DEPTH);
  localparam int PROD_W = 2 * mm_pkg::ELEM_W;
  localparam int ACC_W  = PROD_W + IDX_W + 1;
  localparam logic [mm_pkg::DIM_W-1:0] MAX_DIM4 = mm_pkg::DIM_W'(MAX_DIM);

  // Size registers.
  logic [mm_pkg::DIM_W-1:0] num_rows_r, inner_dim_r, num_cols_r;

  // Control.
  mm_pkg::mm_state_t state_r, state_nxt;
  logic [IDX_W-1:0] i_r, i_nxt, j_r, j_nxt, k_r, k_nxt;
  logic [IDX_W-1:0] row_lim, inner_lim, col_lim;
  logic in_fire, issue, out_load, elem_last;

  // Memories and pipeline.
  logic [mm_pkg::ELEM_W-1:0] a_mem [DEPTH];
  logic [mm_pkg::ELEM_W-1:0] b_mem [DEPTH];
  logic signed [mm_pkg::ELEM_W-1:0] a_rd_r, b_rd_r;
  logic [AW-1:0] wr_addr, a_raddr, b_raddr;
  logic idx_ok, a_we, b_we;
  logic rd_vld_r, rd_first_r, rd_last_r;
  logic mul_vld_r, mul_first_r, mul_last_r;
  logic signed [PROD_W-1:0] prod_r, prod_nxt;
  logic signed [ACC_W-1:0] acc_r, acc_nxt, acc_shift;
  logic acc_done_r;
  logic fits, sat_flag;
  logic [mm_pkg::ELEM_W-1:0] sat_value;

  // Output register.
  logic out_valid_r;
  logic [2:0] out_row_r, out_col_r;
  logic signed [mm_pkg::ELEM_W-1:0] out_value_r;
  logic out_sat_r, out_last_r;

  // A size of zero acts as one and a size above the maximum acts as the maximum.
  function automatic logic [IDX_W-1:0] dim_lim(input logic [mm_pkg::DIM_W-1:0] v);
    logic [mm_pkg::DIM_W-1:0] e;
    if (v == '0) begin
      e = mm_pkg::DIM_W'(1);
    end else if (v > MAX_DIM4) begin
      e = MAX_DIM4;
    end else begin
      e = v;
    end
    return IDX_W'(e - mm_pkg::DIM_W'(1));
  endfunction

  assign row_lim   = dim_lim(num_rows_r);
  assign inner_lim = dim_lim(inner_dim_r);
  assign col_lim   = dim_lim(num_cols_r);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_rows_r  <= mm_pkg::DIM_RESET;
      inner_dim_r <= mm_pkg::DIM_RESET;
      num_cols_r  <= mm_pkg::DIM_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        mm_pkg::CFG_NUM_ROWS:  num_rows_r  <= cfg_data;
        mm_pkg::CFG_INNER_DIM: inner_dim_r <= cfg_data;
        mm_pkg::CFG_NUM_COLS:  num_cols_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Load path.
  assign in_fire = in_valid && in_ready;
  assign idx_ok  = ({1'b0, in_elem_row} < MAX_DIM4) && ({1'b0, in_elem_col} < MAX_DIM4);
  assign a_we    = in_fire && idx_ok && (in_req_type == mm_pkg::REQ_LOAD_A);
  assign b_we    = in_fire && idx_ok && (in_req_type == mm_pkg::REQ_LOAD_B);
  assign wr_addr = AW'(in_elem_row) * AW'(MAX_DIM) + AW'(in_elem_col);

  assign a_raddr = AW'(i_r) * AW'(MAX_DIM) + AW'(k_r);
  assign b_raddr = AW'(k_r) * AW'(MAX_DIM) + AW'(j_r);

  always_ff @(posedge clk) begin
    if (a_we) begin
      a_mem[wr_addr] <= in_elem_value;
    end
    a_rd_r <= a_mem[a_raddr];
  end

  always_ff @(posedge clk) begin
    if (b_we) begin
      b_mem[wr_addr] <= in_elem_value;
    end
    b_rd_r <= b_mem[b_raddr];
  end

  assign elem_last = (i_r == row_lim) && (j_r == col_lim);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mm_pkg::ST_IDLE: begin
        if (in_fire && (in_req_type == mm_pkg::REQ_COMPUTE)) begin
          state_nxt = mm_pkg::ST_RUN;
        end
      end
      mm_pkg::ST_RUN: begin
        if (k_r == inner_lim) begin
          state_nxt = mm_pkg::ST_DRAIN;
        end
      end
      mm_pkg::ST_DRAIN: begin
        if (out_load) begin
          state_nxt = elem_last ? mm_pkg::ST_IDLE : mm_pkg::ST_RUN;
        end
      end
      default: state_nxt = mm_pkg::ST_IDLE;
    endcase
  end

  // State outputs.
  always_comb begin
    in_ready = 1'b0;
    issue    = 1'b0;
    out_load = 1'b0;
    case (state_r)
      mm_pkg::ST_IDLE:  in_ready = 1'b1;
      mm_pkg::ST_RUN:   issue    = 1'b1;
      mm_pkg::ST_DRAIN: out_load = acc_done_r && (!out_valid_r || out_ready);
      default: ;
    endcase
  end

  // Index counters: k walks the inner dimension, j then i step after each result.
  always_comb begin
    i_nxt = i_r;
    j_nxt = j_r;
    k_nxt = k_r;
    if (in_fire && (state_r == mm_pkg::ST_IDLE)) begin
      i_nxt = '0;
      j_nxt = '0;
      k_nxt = '0;
    end else if (issue && (k_r != inner_lim)) begin
      k_nxt = k_r + IDX_W'(1);
    end else if (out_load) begin
      k_nxt = '0;
      if (j_r == col_lim) begin
        j_nxt = '0;
        i_nxt = i_r + IDX_W'(1);
      end else begin
        j_nxt = j_r + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mm_pkg::ST_IDLE;
      i_r     <= '0;
      j_r     <= '0;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      k_r     <= k_nxt;
    end
  end

  // Multiply-accumulate pipeline.
  assign prod_nxt = a_rd_r * b_rd_r;
  assign acc_nxt  = (mul_first_r ? ACC_W'(0) : acc_r) + ACC_W'(prod_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r   <= 1'b0;
      mul_vld_r  <= 1'b0;
      acc_done_r <= 1'b0;
    end else begin
      rd_vld_r  <= issue;
      mul_vld_r <= rd_vld_r;
      if (mul_vld_r && mul_last_r) begin
        acc_done_r <= 1'b1;
      end else if (out_load) begin
        acc_done_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_first_r  <= (k_r == '0);
    rd_last_r   <= (k_r == inner_lim);
    mul_first_r <= rd_first_r;
    mul_last_r  <= rd_last_r;
    prod_r      <= prod_nxt;
    if (mul_vld_r) begin
      acc_r <= acc_nxt;
    end
  end

  // Floor by the fraction bits, then clip to the 32-bit range.
  assign acc_shift = acc_r >>> FRAC_BITS;
  assign fits      = (acc_shift[ACC_W-1:mm_pkg::ELEM_W-1] == '0) ||
                     (acc_shift[ACC_W-1:mm_pkg::ELEM_W-1] == '1);
  assign sat_flag  = !fits;
  assign sat_value = acc_r[ACC_W-1] ? {1'b1, {(mm_pkg::ELEM_W-1){1'b0}}}
                                    : {1'b0, {(mm_pkg::ELEM_W-1){1'b1}}};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_row_r   <= 3'(i_r);
      out_col_r   <= 3'(j_r);
      out_value_r <= fits ? acc_shift[mm_pkg::ELEM_W-1:0] : sat_value;
      out_sat_r   <= sat_flag;
      out_last_r  <= elem_last;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_row           = out_row_r;
  assign out_col           = out_col_r;
  assign out_product_value = out_value_r;
  assign out_saturated     = out_sat_r;
  assign out_last          = out_last_r;

endmodule

// ===== sv/mm_checker.sv =====
`timescale 1ns / 1ps
`include "matrix_multiply_core_macros.svh"

module mm_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_product_value,
  input logic        out_saturated,
  input logic        out_last
);

  `MM_ASSERT_AFTER_RESET(a_reset_idle, !out_valid)
  `MM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_product_value) && $stable(out_last))
  `MM_ASSERT_NOW(a_sat_clip, out_valid && out_saturated, (out_product_value == 32'h7fffffff) || (out_product_value == 32'h80000000))
  // While a result that is not the final one of its run waits, the run is still busy.
  `MM_ASSERT_NOW(a_busy_in_run, out_valid && !out_last, !in_ready)

endmodule

bind matrix_multiply_core mm_checker u_mm_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_ready          (in_ready),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_product_value (out_product_value),
  .out_saturated     (out_saturated),
  .out_last          (out_last)
);
